/* hw/rtl/kms_pkg.sv */
`default_nettype none

package kms_pkg;

    // matrix geometry
    localparam int COLUMNS      = 8;
    localparam int SHIFT_REGS   = 2;
    localparam int ROWS         = 16;
    localparam int KEYS         = 128;
    localparam int HISTORY_BITS = 16;
    localparam int MAX_COUNT    = 16;
    localparam int BITS_PER_REG = 8;

    localparam int POSITIONS = SHIFT_REGS * BITS_PER_REG;

    // store geometry
    localparam int KEY_W    = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int CNT_W    = $clog2(MAX_COUNT + 1);
    localparam int WORD_W   = HISTORY_BITS + CNT_W;
    localparam int CALC_W   = 12;

    // fixed field widths
    localparam int COLUMN_W    = 3;
    localparam int ROW_W       = 4;
    localparam int KEY_INDEX_W = 8;
    localparam int OUT_CNT_W   = 5;
    localparam int OUT_HIST_W  = 16;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_READ   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [COLUMN_W-1:0]    column;
        logic [ROW_W-1:0]       row;
        logic                   level;
        logic [KEY_INDEX_W-1:0] key_index;
    } t_in_item;

    typedef struct packed {
        logic                  in_range;
        logic                  has_new;
        logic [OUT_CNT_W-1:0]  sample_count;
        logic [OUT_HIST_W-1:0] history;
    } t_out_item;

endpackage

`default_nettype wire

/* hw/rtl/kms_if.sv */
`default_nettype none

interface kms_in_if;
    logic               valid;
    logic               ready;
    kms_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kms_out_if;
    logic               valid;
    logic               ready;
    kms_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/key_matrix_sample_history_store.sv */
// channel  | dir | payload                                   | handshake
// i_in     | in  | kind, column, row, level, key_index       | valid / ready
// o_out    | out | in_range, has_new, sample_count, history  | valid / ready
//
// one word accepted per cycle unless stalled; the entry is read from the store ram in the
// accept cycle and modified and written back in the second stage, where a read
// result also lands in the output register
// a write back to the entry being read in the same cycle is forwarded
// reset clears the control state and all per-entry valid bits
// a result held by o_out.ready low stalls a read in the second stage and then i_in
`default_nettype none

module key_matrix_sample_history_store (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kms_in_if.sink     i_in,
    kms_out_if.source  o_out
);

    // accept side
    logic                        in_acc;
    logic                        acc_hit;
    logic [kms_pkg::CALC_W-1:0]  calc_addr;
    logic [kms_pkg::KEY_W-1:0]   acc_addr;

    // second stage
    logic                        r_s1_valid;
    kms_pkg::t_kind              r_s1_kind;
    logic                        r_s1_hit;
    logic [kms_pkg::KEY_W-1:0]   r_s1_addr;
    logic                        r_s1_level;
    logic                        r_s1_fwd;
    logic [kms_pkg::WORD_W-1:0]  r_s1_fwd_data;
    logic                        s1_adv;

    logic [kms_pkg::WORD_W-1:0]        ram_rdata;
    logic [kms_pkg::WORD_W-1:0]        entry;
    logic [kms_pkg::HISTORY_BITS-1:0]  hist;
    logic [kms_pkg::CNT_W-1:0]         cnt;
    logic [kms_pkg::HISTORY_BITS-1:0]  new_hist;
    logic [kms_pkg::CNT_W-1:0]         new_cnt;
    logic                              wr_en;
    logic [kms_pkg::WORD_W-1:0]        wr_data;

    logic [kms_pkg::KEYS-1:0]          r_valid;

    logic                              r_out_valid;
    kms_pkg::t_out_item                r_out;
    kms_pkg::t_out_item                n_out;
    logic                              out_load;

    logic [kms_pkg::HISTORY_BITS+kms_pkg::OUT_HIST_W-1:0] hist_ext;
    logic [kms_pkg::CNT_W+kms_pkg::OUT_CNT_W-1:0]         cnt_ext;

    // address decode at accept, row reversed for msb-first shifting
    always_comb begin
        calc_addr = (kms_pkg::CALC_W'(kms_pkg::POSITIONS - 1)
                     - kms_pkg::CALC_W'(i_in.data.row))
                    * kms_pkg::CALC_W'(kms_pkg::COLUMNS)
                    + kms_pkg::CALC_W'(i_in.data.column);
        if (i_in.data.kind == kms_pkg::KIND_SAMPLE) begin
            acc_addr = calc_addr[kms_pkg::KEY_W-1:0];
            acc_hit  = (i_in.data.column < kms_pkg::COLUMNS)
                    && (i_in.data.row < kms_pkg::ROWS)
                    && (i_in.data.row < kms_pkg::POSITIONS)
                    && (calc_addr < kms_pkg::CALC_W'(kms_pkg::KEYS));
        end else begin
            acc_addr = i_in.data.key_index[kms_pkg::KEY_W-1:0];
            acc_hit  = (i_in.data.key_index < kms_pkg::KEYS);
        end
    end

    assign s1_adv     = r_s1_valid
                     && ((r_s1_kind == kms_pkg::KIND_SAMPLE) || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    kms_ram #(
        .WIDTH (kms_pkg::WORD_W),
        .DEPTH (kms_pkg::KEYS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_data),
        .i_re    (in_acc),
        .i_raddr (acc_addr),
        .o_rdata (ram_rdata)
    );

    // modify stage
    always_comb begin
        if (r_s1_fwd) begin
            entry = r_s1_fwd_data;
        end else if (r_valid[r_s1_addr]) begin
            entry = ram_rdata;
        end else begin
            entry = '0;
        end
        hist     = entry[kms_pkg::WORD_W-1:kms_pkg::CNT_W];
        cnt      = entry[kms_pkg::CNT_W-1:0];
        new_hist = kms_pkg::HISTORY_BITS'({hist, ~r_s1_level});
        if (cnt < kms_pkg::CNT_W'(kms_pkg::MAX_COUNT)) begin
            new_cnt = cnt + kms_pkg::CNT_W'(1);
        end else begin
            new_cnt = kms_pkg::CNT_W'(kms_pkg::MAX_COUNT);
        end
        wr_en = s1_adv && r_s1_hit;
        if (r_s1_kind == kms_pkg::KIND_SAMPLE) begin
            wr_data = {new_hist, new_cnt};
        end else begin
            wr_data = {hist, kms_pkg::CNT_W'(0)};
        end

        hist_ext = {kms_pkg::OUT_HIST_W'(0), hist};
        cnt_ext  = {kms_pkg::OUT_CNT_W'(0), cnt};
        out_load = s1_adv && (r_s1_kind == kms_pkg::KIND_READ);
        if (r_s1_hit) begin
            n_out.in_range     = 1'b1;
            n_out.has_new      = (cnt != '0);
            n_out.sample_count = cnt_ext[kms_pkg::OUT_CNT_W-1:0];
            n_out.history      = hist_ext[kms_pkg::OUT_HIST_W-1:0];
        end else begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (wr_en) begin
                r_valid[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind     <= i_in.data.kind;
            r_s1_hit      <= acc_hit;
            r_s1_addr     <= acc_addr;
            r_s1_level    <= i_in.data.level;
            // same-entry write back this cycle is not yet in the ram read word
            r_s1_fwd      <= wr_en && (r_s1_addr == acc_addr);
            r_s1_fwd_data <= wr_data;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

/* hw/rtl/kms_ram.sv */
`default_nettype none

module kms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/kms_checker.sv */
`default_nettype none

module kms_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_out_valid,
    input wire logic                            i_out_ready,
    input wire logic                            i_in_range,
    input wire logic                            i_has_new,
    input wire logic [kms_pkg::OUT_CNT_W-1:0]   i_sample_count,
    input wire logic [kms_pkg::OUT_HIST_W-1:0]  i_history
);

    // a held result keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid
            && $stable(i_history) && $stable(i_sample_count)
            && $stable(i_has_new) && $stable(i_in_range)))
        else $error("result changed while stalled");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_in_range) |->
            (!i_has_new && (i_sample_count == '0) && (i_history == '0)))
        else $error("out of range read returned data");

    a_new_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_has_new == (i_sample_count != '0)))
        else $error("new flag disagrees with count");

    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_sample_count <= kms_pkg::OUT_CNT_W'(kms_pkg::MAX_COUNT)))
        else $error("count above saturation");

endmodule

bind key_matrix_sample_history_store kms_checker u_kms_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_in_range     (o_out.data.in_range),
    .i_has_new      (o_out.data.has_new),
    .i_sample_count (o_out.data.sample_count),
    .i_history      (o_out.data.history)
);

`default_nettype wire
